@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is low
`define SPDC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spdc assertion failed");

// concurrent assertion, also checked during reset
`define SPDC_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spdc assertion failed");

`endif

@@ rtl/spdc_pkg.sv @@
// types and constants of the staged delayed pulse channel
// no dependencies
package spdc_pkg;

  localparam int DELAY_W  = 31;
  localparam int TICKS_W  = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_EXPIRY   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_STEP = 2'd2;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST  = 31'd20000000;
  localparam logic [TICKS_W-1:0] STAGE_THR_RST  = 16'd40000;
  localparam logic [TICKS_W-1:0] STAGE_STEP_RST = 16'd30000;

  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_FOLLOW = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_ON     = 3'd3,
    ACT_OFF    = 3'd4,
    ACT_DROP   = 3'd5
  } action_t;

  typedef struct packed {
    logic [DELAY_W-1:0] max_delay;
    logic [TICKS_W-1:0] stage_thr;
    logic [TICKS_W-1:0] stage_step;
  } cfg_t;

  // queue entry: delay plus stamp folded into one sum
  typedef struct packed {
    logic               op;
    logic [TICKS_W-1:0] wid;
    logic [TIME_W-1:0]  sum;
    logic [TIME_W-1:0]  now;
  } entry_t;

endpackage

@@ rtl/spdc_intf.sv @@
// channel interfaces of the staged delayed pulse channel
// depends on spdc_pkg
interface spdc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [spdc_pkg::DELAY_W-1:0] start_delay;
  logic [spdc_pkg::TICKS_W-1:0] width;
  logic [spdc_pkg::TIME_W-1:0]  request_time;
  logic [spdc_pkg::TIME_W-1:0]  time_now;

  modport source(output valid, operation, start_delay, width, request_time, time_now,
                 input ready);
  modport sink(input valid, operation, start_delay, width, request_time, time_now,
               output ready);
endinterface

interface spdc_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   action;
  logic [spdc_pkg::TICKS_W-1:0] timer_ticks;
  logic                         last_of_run;

  modport source(output valid, action, timer_ticks, last_of_run, input ready);
  modport sink(input valid, action, timer_ticks, last_of_run, output ready);
endinterface

interface spdc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spdc_pkg::CFG_IDX_W-1:0]  index;
  logic [spdc_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/spdc_front.sv @@
// front stage: takes input beats, masks the width, folds delay and stamp
// depends on spdc_pkg and spdc_intf
module spdc_front #(
  parameter int WIDTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  spdc_in_if.sink           in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output spdc_pkg::entry_t  push_data
);

  localparam int PW = (WIDTH_BITS < spdc_pkg::TICKS_W) ? WIDTH_BITS : spdc_pkg::TICKS_W;

  logic             fr_valid_r;
  logic             fr_valid_nxt;
  spdc_pkg::entry_t fr_entry_r;
  spdc_pkg::entry_t fr_entry_nxt;
  logic             in_take;

  assign in_ch.ready = !fr_valid_r || push_ready;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign push_valid  = fr_valid_r;
  assign push_data   = fr_entry_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r && !push_ready;
    fr_entry_nxt = fr_entry_r;
    if (in_take) begin
      fr_valid_nxt     = 1'b1;
      fr_entry_nxt.op  = in_ch.operation;
      fr_entry_nxt.wid = spdc_pkg::TICKS_W'(in_ch.width[PW-1:0]);
      fr_entry_nxt.sum = spdc_pkg::TIME_W'(in_ch.start_delay) + in_ch.request_time;
      fr_entry_nxt.now = in_ch.time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_entry_r <= fr_entry_nxt;
  end

endmodule

@@ rtl/spdc_queue.sv @@
// two-entry queue between front and back
// depends on spdc_pkg
module spdc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  spdc_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop,
  output spdc_pkg::entry_t pop_data
);

  spdc_pkg::entry_t                  mem_r [spdc_pkg::QDEPTH];
  logic [spdc_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [spdc_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [spdc_pkg::QCNT_W-1:0]       cnt_r;
  logic [spdc_pkg::QCNT_W-1:0]       cnt_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = cnt_r != spdc_pkg::QCNT_W'(spdc_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/spdc_back.sv @@
// back stage: channel phase, pending slot, pulse sequencer and result register
// depends on spdc_pkg and spdc_intf
module spdc_back #(
  parameter int WIDTH_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spdc_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  spdc_pkg::entry_t q_data,
  output logic             q_pop,
  spdc_out_if.source       out_ch
);

  localparam int PW = (WIDTH_BITS < spdc_pkg::TICKS_W) ? WIDTH_BITS : spdc_pkg::TICKS_W;
  localparam int DW = spdc_pkg::DELAY_W;
  localparam int TW = spdc_pkg::TICKS_W;
  localparam int MW = spdc_pkg::TIME_W;

  typedef enum logic [1:0] {BK_IDLE, BK_PULSE, BK_STOP, BK_START} bk_state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_STAGED, PH_ACTIVE} phase_t;

  bk_state_t         bk_state_r, bk_state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [DW-1:0]     delay_left_r, delay_left_nxt;
  logic [PW-1:0]     pulse_r, pulse_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [MW-1:0]     pend_sum_r, pend_sum_nxt;
  logic [TW-1:0]     pend_wid_r, pend_wid_nxt;
  logic [MW-1:0]     now_r, now_nxt;
  logic [MW-1:0]     diff_r, diff_nxt;
  logic [TW-1:0]     w_r, w_nxt;
  logic              out_valid_r, out_valid_nxt;
  spdc_pkg::action_t out_act_r, out_act_nxt;
  logic [TW-1:0]     out_ticks_r, out_ticks_nxt;
  logic              out_last_r, out_last_nxt;

  logic              emit_ok;
  logic [DW-1:0]     thr_ext;
  logic [DW-1:0]     step_ext;
  logic [MW:0]       wsum;
  logic [TW-1:0]     w_late;
  logic [TW-1:0]     w_new;
  logic [DW-1:0]     init;
  logic              st_drop;
  logic              st_staged;
  logic [DW-1:0]     st_left;
  logic [DW-1:0]     fo_left;

  assign emit_ok  = !out_valid_r || out_ch.ready;
  assign thr_ext  = DW'(cfg.stage_thr);
  assign step_ext = DW'(cfg.stage_step);

  // latency correction of a started request
  assign wsum   = {{(MW + 1 - TW){1'b0}}, w_r} + {diff_r[MW-1], diff_r};
  assign w_late = (!wsum[MW] && (wsum[TW-1:0] != '0)) ? wsum[TW-1:0] : '0;
  assign w_new  = diff_r[MW-1] ? w_late : w_r;
  assign init   = diff_r[MW-1] ? '0 : diff_r[DW-1:0];
  assign st_drop   = init > cfg.max_delay;
  assign st_staged = init > thr_ext;
  assign st_left   = (st_staged && (init > step_ext)) ? (init - step_ext) : '0;
  assign fo_left   = (delay_left_r > step_ext) ? (delay_left_r - step_ext) : '0;

  assign q_pop = (bk_state_r == BK_IDLE) && q_valid && emit_ok;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = out_act_r;
  assign out_ch.timer_ticks = out_ticks_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    bk_state_nxt   = bk_state_r;
    phase_nxt      = phase_r;
    delay_left_nxt = delay_left_r;
    pulse_nxt      = pulse_r;
    pend_valid_nxt = pend_valid_r;
    pend_sum_nxt   = pend_sum_r;
    pend_wid_nxt   = pend_wid_r;
    now_nxt        = now_r;
    diff_nxt       = diff_r;
    w_nxt          = w_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_act_nxt    = out_act_r;
    out_ticks_nxt  = out_ticks_r;
    out_last_nxt   = out_last_r;
    unique case (bk_state_r)
      BK_IDLE: begin
        if (q_pop) begin
          if (q_data.op == spdc_pkg::OP_SCHEDULE) begin
            if (phase_r != PH_IDLE) begin
              pend_valid_nxt = 1'b1;
              pend_sum_nxt   = q_data.sum;
              pend_wid_nxt   = q_data.wid;
            end else begin
              diff_nxt     = q_data.sum - q_data.now;
              w_nxt        = q_data.wid;
              bk_state_nxt = BK_START;
            end
          end else begin
            unique case (phase_r)
              PH_STAGED: begin
                out_valid_nxt = 1'b1;
                out_act_nxt   = spdc_pkg::ACT_FOLLOW;
                out_last_nxt  = 1'b1;
                if (delay_left_r > thr_ext) begin
                  delay_left_nxt = fo_left;
                  out_ticks_nxt  = cfg.stage_step;
                end else begin
                  phase_nxt      = PH_WAIT;
                  out_ticks_nxt  = delay_left_r[TW-1:0];
                  delay_left_nxt = '0;
                end
              end
              PH_WAIT: begin
                out_valid_nxt = 1'b1;
                out_act_nxt   = spdc_pkg::ACT_ON;
                out_ticks_nxt = '0;
                out_last_nxt  = 1'b0;
                phase_nxt     = PH_ACTIVE;
                bk_state_nxt  = BK_PULSE;
              end
              PH_ACTIVE: begin
                out_valid_nxt = 1'b1;
                out_act_nxt   = spdc_pkg::ACT_OFF;
                out_ticks_nxt = '0;
                out_last_nxt  = 1'b0;
                now_nxt       = q_data.now;
                bk_state_nxt  = BK_STOP;
              end
              PH_IDLE: begin
              end
            endcase
          end
        end
      end
      BK_PULSE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = spdc_pkg::ACT_FOLLOW;
          out_ticks_nxt = TW'(pulse_r);
          out_last_nxt  = 1'b1;
          bk_state_nxt  = BK_IDLE;
        end
      end
      BK_STOP: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = spdc_pkg::ACT_STOP;
          out_ticks_nxt = '0;
          out_last_nxt  = !pend_valid_r;
          phase_nxt     = PH_IDLE;
          if (pend_valid_r) begin
            pend_valid_nxt = 1'b0;
            diff_nxt       = pend_sum_r - now_r;
            w_nxt          = pend_wid_r;
            bk_state_nxt   = BK_START;
          end else begin
            bk_state_nxt = BK_IDLE;
          end
        end
      end
      BK_START: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          bk_state_nxt  = BK_IDLE;
          if (st_drop) begin
            out_act_nxt   = spdc_pkg::ACT_DROP;
            out_ticks_nxt = '0;
          end else begin
            out_act_nxt    = spdc_pkg::ACT_START;
            pulse_nxt      = w_new[PW-1:0];
            delay_left_nxt = st_left;
            if (st_staged) begin
              phase_nxt     = PH_STAGED;
              out_ticks_nxt = cfg.stage_step;
            end else begin
              phase_nxt     = PH_WAIT;
              out_ticks_nxt = init[TW-1:0];
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_state_r   <= BK_IDLE;
      phase_r      <= PH_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bk_state_r   <= bk_state_nxt;
      phase_r      <= phase_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    delay_left_r <= delay_left_nxt;
    pulse_r      <= pulse_nxt;
    pend_sum_r   <= pend_sum_nxt;
    pend_wid_r   <= pend_wid_nxt;
    now_r        <= now_nxt;
    diff_r       <= diff_nxt;
    w_r          <= w_nxt;
    out_act_r    <= out_act_nxt;
    out_ticks_r  <= out_ticks_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

@@ rtl/staged_delayed_pulse_channel_top.sv @@
// path: front register, two-entry queue, back stage and result register, with a start
// from idle passing the BK_START state; throughput: front takes a beat every cycle
// while the queue has room; back pops one item per cycle when idle and out_ch is free
// reset: synchronous active low; clears queue, phase, pending slot and result
// register; configuration returns to its defaults; cfg writes always accepted
module staged_delayed_pulse_channel_top #(
  parameter int WIDTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  spdc_in_if.sink    in_ch,
  spdc_out_if.source out_ch,
  spdc_cfg_if.sink   cfg_ch
);

  spdc_pkg::cfg_t   cfg_r;
  spdc_pkg::cfg_t   cfg_nxt;
  logic             push_valid;
  logic             push_ready;
  spdc_pkg::entry_t push_data;
  logic             q_valid;
  logic             q_pop;
  spdc_pkg::entry_t q_data;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        spdc_pkg::CFG_MAX_DELAY:  cfg_nxt.max_delay  = cfg_ch.data;
        spdc_pkg::CFG_STAGE_THR:  cfg_nxt.stage_thr  = cfg_ch.data[spdc_pkg::TICKS_W-1:0];
        spdc_pkg::CFG_STAGE_STEP: cfg_nxt.stage_step = cfg_ch.data[spdc_pkg::TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_delay  <= spdc_pkg::MAX_DELAY_RST;
      cfg_r.stage_thr  <= spdc_pkg::STAGE_THR_RST;
      cfg_r.stage_step <= spdc_pkg::STAGE_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spdc_front #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  spdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  spdc_back #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/spdc_checker.sv @@
// port-level checks of the staged delayed pulse channel, bound to the top level
// depends on spdc_pkg and assert_macros.svh
`include "assert_macros.svh"

module spdc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_action,
  input logic [15:0] out_ticks,
  input logic       out_last
);

  `SPDC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_ticks) && $stable(out_last))
  `SPDC_ASSERT(a_start_last, clk, rst_n, out_valid && (out_action == spdc_pkg::ACT_START || out_action == spdc_pkg::ACT_DROP) |-> out_last)
  `SPDC_ASSERT(a_on_then_width, clk, rst_n, out_valid && out_ready && out_action == spdc_pkg::ACT_ON |=> out_valid && out_action == spdc_pkg::ACT_FOLLOW && out_last)
  `SPDC_ASSERT(a_edge_no_ticks, clk, rst_n, out_valid && (out_action == spdc_pkg::ACT_ON || out_action == spdc_pkg::ACT_OFF || out_action == spdc_pkg::ACT_STOP || out_action == spdc_pkg::ACT_DROP) |-> out_ticks == 16'd0)
  `SPDC_ASSERT_NORST(a_rst_clears, clk, !rst_n |=> !out_valid)

endmodule

bind staged_delayed_pulse_channel_top spdc_checker u_spdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_action (out_ch.action),
  .out_ticks  (out_ch.timer_ticks),
  .out_last   (out_ch.last_of_run)
);

@@ verif/tb_top.sv @@
// self-checking bench for the staged delayed pulse channel: a directed table, then random
// schedule and expiry traffic under several register settings, checked beat by beat
// depends on spdc_pkg, spdc_intf and staged_delayed_pulse_channel_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = spdc_pkg::DELAY_W;
  localparam int TW = spdc_pkg::TICKS_W;
  localparam int MW = spdc_pkg::TIME_W;
  localparam int IW = spdc_pkg::CFG_IDX_W;
  localparam int VW = spdc_pkg::CFG_DATA_W;

  localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 500000;
  localparam int HOLD_CYCLES = 80;
  localparam int ITEMS_PER_SETTING = 28;

  typedef enum logic [1:0] {CH_IDLE, CH_WAIT, CH_STAGED, CH_ACTIVE} ch_phase_t;

  typedef struct packed {
    spdc_pkg::action_t act;
    logic [TW-1:0]     ticks;
    logic              last;
  } timer_cmd_t;

  typedef struct packed {
    logic                        op;
    logic [DW-1:0]               delay;
    logic [TW-1:0]               wid;
    logic [MW-1:0]               stamp;
    logic [MW-1:0]               now;
    logic                        typed;
    logic [1:0]                  n;
    spdc_pkg::action_t [2:0]     act;
    logic [2:0][TW-1:0]          ticks;
  } plan_row_t;

  logic clk;
  logic rst_n;

  spdc_in_if  in_ch();
  spdc_out_if out_ch();
  spdc_cfg_if cfg_ch();

  staged_delayed_pulse_channel_top #(.WIDTH_BITS(16)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // channel model state
  logic [DW-1:0] max_delay_q;
  logic [TW-1:0] stage_thr_q;
  logic [TW-1:0] stage_step_q;
  ch_phase_t     ch_phase;
  logic [31:0]   delay_left;
  logic [TW-1:0] pulse_ticks;
  bit            held_valid;
  logic [DW-1:0] held_delay;
  logic [TW-1:0] held_width;
  logic [MW-1:0] held_stamp;

  timer_cmd_t  step_cmds[$];
  timer_cmd_t  timer_cmds_due[$];
  plan_row_t   plan[$];
  int          errors;
  bit          calm;
  bit          hold_req;
  int unsigned cycles;

  function automatic plan_row_t row(logic op, logic [DW-1:0] delay,
                                    logic [TW-1:0] wid, logic [MW-1:0] stamp,
                                    logic [MW-1:0] now, logic typed = 1'b0, int n = 0,
                                    spdc_pkg::action_t a0 = spdc_pkg::ACT_START,
                                    logic [TW-1:0] t0 = '0,
                                    spdc_pkg::action_t a1 = spdc_pkg::ACT_START,
                                    logic [TW-1:0] t1 = '0,
                                    spdc_pkg::action_t a2 = spdc_pkg::ACT_START,
                                    logic [TW-1:0] t2 = '0);
    plan_row_t r;
    r.op = op;
    r.delay = delay;
    r.wid = wid;
    r.stamp = stamp;
    r.now = now;
    r.typed = typed;
    r.n = n[1:0];
    r.act[0] = a0;
    r.act[1] = a1;
    r.act[2] = a2;
    r.ticks[0] = t0;
    r.ticks[1] = t1;
    r.ticks[2] = t2;
    return r;
  endfunction

  function automatic void emit(spdc_pkg::action_t act, logic [TW-1:0] ticks);
    step_cmds.push_back('{act, ticks, 1'b0});
  endfunction

  // latency correction, late trimming of the width, drop and staging
  function automatic void launch(logic [DW-1:0] delay, logic [TW-1:0] wid,
                                 logic [MW-1:0] stamp, logic [MW-1:0] now);
    logic [31:0] corr;
    logic [31:0] late;
    logic [31:0] w;
    corr = {1'b0, delay} - (now - stamp);
    w = {16'b0, wid};
    if (corr[31]) begin
      late = 32'd0 - corr;
      w = (late >= w) ? 32'd0 : w - late;
      corr = '0;
    end
    if (corr > {1'b0, max_delay_q}) begin
      emit(spdc_pkg::ACT_DROP, '0);
      return;
    end
    pulse_ticks = w[TW-1:0];
    if (corr > {16'b0, stage_thr_q}) begin
      delay_left = (corr > {16'b0, stage_step_q}) ? corr - stage_step_q : 32'd0;
      ch_phase = CH_STAGED;
      emit(spdc_pkg::ACT_START, stage_step_q);
    end else begin
      delay_left = '0;
      ch_phase = CH_WAIT;
      emit(spdc_pkg::ACT_START, corr[TW-1:0]);
    end
  endfunction

  function automatic void channel_step(logic op, logic [DW-1:0] delay,
                                       logic [TW-1:0] wid, logic [MW-1:0] stamp,
                                       logic [MW-1:0] now);
    step_cmds.delete();
    if (op == spdc_pkg::OP_SCHEDULE) begin
      if (ch_phase != CH_IDLE) begin
        held_delay = delay;
        held_width = wid;
        held_stamp = stamp;
        held_valid = 1'b1;
      end else begin
        launch(delay, wid, stamp, now);
      end
    end else begin
      case (ch_phase)
        CH_STAGED: begin
          if (delay_left > {16'b0, stage_thr_q}) begin
            delay_left = (delay_left > {16'b0, stage_step_q}) ? delay_left - stage_step_q
                                                              : 32'd0;
            emit(spdc_pkg::ACT_FOLLOW, stage_step_q);
          end else begin
            ch_phase = CH_WAIT;
            emit(spdc_pkg::ACT_FOLLOW, delay_left[TW-1:0]);
            delay_left = '0;
          end
        end
        CH_WAIT: begin
          emit(spdc_pkg::ACT_ON, '0);
          ch_phase = CH_ACTIVE;
          emit(spdc_pkg::ACT_FOLLOW, pulse_ticks);
        end
        CH_ACTIVE: begin
          emit(spdc_pkg::ACT_OFF, '0);
          emit(spdc_pkg::ACT_STOP, '0);
          ch_phase = CH_IDLE;
          if (held_valid) begin
            held_valid = 1'b0;
            launch(held_delay, held_width, held_stamp, now);
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // corrected delay aimed at: late, short, staged or over the drop limit
  function automatic logic [31:0] pick_corrected();
    int r;
    logic [31:0] span;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h8000_0000;
    if (r < 18) return 32'd0 - $urandom_range(1, 70000);
    if (r < 55) return $urandom_range(0, stage_thr_q);
    if (r < 80) return stage_thr_q + 32'd1 + $urandom_range(0, 5 * stage_step_q);
    if (max_delay_q == '1) return $urandom_range(0, stage_thr_q);
    span = 32'h7FFF_FFFF - max_delay_q - 32'd1;
    if (span > 1000) span = 1000;
    return max_delay_q + 32'd1 + $urandom_range(0, span);
  endfunction

  task automatic offer(logic op, logic [DW-1:0] delay, logic [TW-1:0] wid,
                       logic [MW-1:0] stamp, logic [MW-1:0] now, bit predicted);
    int gap;
    timer_cmd_t c;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.start_delay <= delay;
    in_ch.width <= wid;
    in_ch.request_time <= stamp;
    in_ch.time_now <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    channel_step(op, delay, wid, stamp, now);
    if (predicted) begin
      foreach (step_cmds[i]) begin
        c = step_cmds[i];
        c.last = (i == step_cmds.size() - 1);
        timer_cmds_due.push_back(c);
      end
    end
  endtask

  task automatic random_request();
    logic [DW-1:0] delay;
    logic [TW-1:0] wid;
    logic [MW-1:0] now;
    logic [31:0]   corr;
    int            r;
    now = $urandom;
    r = $urandom_range(0, 9);
    wid = (r == 0) ? '0 : (r == 1) ? '1 : 16'($urandom);
    delay = ($urandom_range(0, 1) == 1) ? 31'($urandom) : 31'($urandom_range(0, 200000));
    corr = pick_corrected();
    offer(spdc_pkg::OP_SCHEDULE, delay, wid, now - ({1'b0, delay} - corr), now, 1'b1);
  endtask

  task automatic random_expiry();
    logic [MW-1:0] now;
    now = $urandom;
    // steer the start of a held request so its staging stays short
    if (ch_phase == CH_ACTIVE && held_valid)
      now = held_stamp + ({1'b0, held_delay} - pick_corrected());
    offer(spdc_pkg::OP_EXPIRY, 31'($urandom), 16'($urandom), $urandom, now, 1'b1);
  endtask

  task automatic run_setting(int items);
    int done;
    done = 0;
    while (done < items) begin
      if (ch_phase == CH_IDLE) begin
        if ($urandom_range(0, 7) == 0) begin
          random_expiry();
        end else begin
          random_request();
          done++;
        end
      end else begin
        if ($urandom_range(0, 99) < 12) random_request();
        else random_expiry();
        done++;
      end
    end
    while (ch_phase != CH_IDLE) random_expiry();
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (timer_cmds_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic program_regs(logic [DW-1:0] max_delay, logic [TW-1:0] thr,
                              logic [TW-1:0] stage_step);
    logic [IW-1:0] idx[4];
    logic [VW-1:0] val[4];
    idx = '{CFG_UNUSED, spdc_pkg::CFG_MAX_DELAY, spdc_pkg::CFG_STAGE_THR,
            spdc_pkg::CFG_STAGE_STEP};
    val = '{31'($urandom), max_delay, {15'($urandom), thr}, {15'($urandom), stage_step}};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= val[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (idx[i])
        spdc_pkg::CFG_MAX_DELAY: max_delay_q = val[i];
        spdc_pkg::CFG_STAGE_THR: stage_thr_q = val[i][TW-1:0];
        spdc_pkg::CFG_STAGE_STEP: stage_step_q = val[i][TW-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // result side ready with random stalls and one long hold
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    timer_cmd_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (timer_cmds_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got action %0d ticks %0d last %0b",
                   $time, out_ch.action, out_ch.timer_ticks, out_ch.last_of_run);
        end else begin
          want = timer_cmds_due.pop_front();
          if (out_ch.action !== want.act || out_ch.timer_ticks !== want.ticks ||
              out_ch.last_of_run !== want.last) begin
            errors++;
            $display("%0t: beat mismatch, expected action %0d ticks %0d last %0b,",
                     $time, want.act, want.ticks, want.last);
            $display("%0t: got action %0d ticks %0d last %0b", $time, out_ch.action,
                     out_ch.timer_ticks, out_ch.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = spdc_pkg::OP_SCHEDULE;
    in_ch.start_delay = '0;
    in_ch.width = '0;
    in_ch.request_time = '0;
    in_ch.time_now = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = spdc_pkg::CFG_MAX_DELAY;
    cfg_ch.data = '0;
    errors = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    max_delay_q = spdc_pkg::MAX_DELAY_RST;
    stage_thr_q = spdc_pkg::STAGE_THR_RST;
    stage_step_q = spdc_pkg::STAGE_STEP_RST;
    ch_phase = CH_IDLE;
    delay_left = '0;
    pulse_ticks = '0;
    held_valid = 1'b0;
    held_delay = '0;
    held_width = '0;
    held_stamp = '0;

    // expiry while idle, request held while busy and started at pulse end
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0, 1'b1, 0));
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd100, 16'd50, 32'd1000, 32'd1000, 1'b1, 1,
                       spdc_pkg::ACT_START, 16'd100));
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd0, 16'd7, 32'd5, 32'd5, 1'b1, 0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd2000, 1'b1, 2,
                       spdc_pkg::ACT_ON, 16'd0, spdc_pkg::ACT_FOLLOW, 16'd50));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd10, 1'b1, 3,
                       spdc_pkg::ACT_OFF, 16'd0, spdc_pkg::ACT_STOP, 16'd0,
                       spdc_pkg::ACT_START, 16'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0, 1'b1, 2,
                       spdc_pkg::ACT_ON, 16'd0, spdc_pkg::ACT_FOLLOW, 16'd2));
    // field extremes and drops
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'h7FFF_FFFF, 16'hFFFF, 32'd0, 32'd0,
                       1'b1, 0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0, 1'b1, 3,
                       spdc_pkg::ACT_OFF, 16'd0, spdc_pkg::ACT_STOP, 16'd0,
                       spdc_pkg::ACT_DROP, 16'd0));
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd20000001, 16'd1, 32'd0, 32'd0, 1'b1, 1,
                       spdc_pkg::ACT_DROP, 16'd0));
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd0, 16'hFFFF, 32'h8000_0000, 32'd0,
                       1'b1, 1, spdc_pkg::ACT_START, 16'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0, 1'b1, 2,
                       spdc_pkg::ACT_ON, 16'd0, spdc_pkg::ACT_FOLLOW, 16'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0, 1'b1, 2,
                       spdc_pkg::ACT_OFF, 16'd0, spdc_pkg::ACT_STOP, 16'd0));
    // stamp in the future
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd100, 16'd9, 32'd250, 32'd200));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));
    // staged wait, ending right at the threshold
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd100000, 16'd300, 32'd7, 32'd7));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));
    // held request replaced by a later one
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd40000, 16'd1, 32'd0, 32'd0));
    plan.push_back(row(spdc_pkg::OP_SCHEDULE, 31'd40001, 16'd2, 32'd0, 32'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row(spdc_pkg::OP_EXPIRY, 31'd0, 16'd0, 32'd0, 32'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].typed) begin
        for (int k = 0; k < plan[i].n; k++)
          timer_cmds_due.push_back('{plan[i].act[k], plan[i].ticks[k], k == plan[i].n - 1});
      end
      offer(plan[i].op, plan[i].delay, plan[i].wid, plan[i].stamp, plan[i].now,
            !plan[i].typed);
    end
    settle();

    program_regs(31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
    calm = 1'b1;
    hold_req = 1'b1;
    run_setting(ITEMS_PER_SETTING);
    calm = 1'b0;
    settle();

    program_regs(31'd0, 16'd1, 16'd1);
    run_setting(ITEMS_PER_SETTING);
    settle();

    program_regs(31'd50000, 16'd1000, 16'hFFFF);
    run_setting(ITEMS_PER_SETTING);
    settle();

    program_regs(spdc_pkg::MAX_DELAY_RST, spdc_pkg::STAGE_THR_RST, spdc_pkg::STAGE_STEP_RST);
    calm = 1'b1;
    run_setting(ITEMS_PER_SETTING);
    calm = 1'b0;
    settle();

    program_regs(31'($urandom_range(0, 1000000)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)));
    run_setting(ITEMS_PER_SETTING);
    settle();

    program_regs(31'd1, 16'hFFFF, 16'd1);
    run_setting(ITEMS_PER_SETTING);
    settle();

    if (errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
